FILE: rtl/ttsm_pkg.sv
// package for the task time stats monitor
// item kinds, command and slot record types, register map indexes
// no dependencies
package ttsm_pkg;

    localparam int unsigned DATA_W     = 16;
    localparam int unsigned SLOT_IN_W  = 4;
    localparam int unsigned SLOT_CMD_W = 6;   // holds any slot of up to 64 slots
    localparam int unsigned REL_W      = 8;   // map offset past the fixed words
    localparam int unsigned CNT_W      = 32;

    // register map
    localparam logic [15:0] RIX_ZERO      = 16'd0;
    localparam logic [15:0] RIX_STACK     = 16'd1;
    localparam logic [15:0] RIX_CNT_LO    = 16'd2;
    localparam logic [15:0] RIX_CNT_HI    = 16'd3;
    localparam logic [15:0] RIX_TASKS     = 16'd4;
    localparam logic [15:0] RIX_SLOT_BASE = 16'd5;

    // reciprocal of three: (x * 171) >> 9 is exact for x below 512
    localparam logic [15:0] RECIP3       = 16'd171;
    localparam int unsigned RECIP3_SHIFT = 9;

    typedef enum logic [1:0] {
        MD_TICK  = 2'd0,
        MD_START = 2'd1,
        MD_STOP  = 2'd2,
        MD_READ  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_START,
        OP_STOP,
        OP_CONST,
        OP_CNT_LO,
        OP_CNT_HI,
        OP_SLOT
    } t_op;

    typedef enum logic [1:0] {
        FS_MIN  = 2'd0,
        FS_LAST = 2'd1,
        FS_MAX  = 2'd2
    } t_fsel;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } t_back_state;

    typedef struct packed {
        t_op                     op;
        logic [SLOT_CMD_W-1:0]   slot;
        t_fsel                   fsel;
        logic [DATA_W-1:0]       time_us;
        logic [DATA_W-1:0]       data;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] start_stamp;
        logic [DATA_W-1:0] last_time;
        logic [DATA_W-1:0] min_time;
        logic [DATA_W-1:0] max_time;
    } t_rec;

    localparam t_rec REC_RESET = '{
        start_stamp: 16'h0000,
        last_time:   16'h0000,
        min_time:    16'hFFFF,
        max_time:    16'h0000
    };

endpackage

FILE: rtl/ttsm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module ttsm_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 9,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ttsm_front.sv
// front end: accepts requests, decodes them into commands, two-entry queue
// depends on ttsm_pkg
module ttsm_front #(
    parameter int unsigned TASKS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_mode,
    input  logic [ttsm_pkg::SLOT_IN_W-1:0]   i_slot,
    input  logic [ttsm_pkg::DATA_W-1:0]      i_time_us,
    input  logic [ttsm_pkg::DATA_W-1:0]      i_read_index,
    input  logic [ttsm_pkg::DATA_W-1:0]      i_stack_peak,
    output logic                             o_cmd_valid,
    output ttsm_pkg::t_cmd                   o_cmd,
    input  logic                             i_cmd_pop
);

    localparam int unsigned SLOTS   = TASKS + 1;
    localparam logic [16:0] MAP_TOP = 17'(4 + 3 * SLOTS);

    ttsm_pkg::t_cmd  dec;
    ttsm_pkg::t_mode mode;
    logic            slot_ok;
    logic            in_map;
    logic [ttsm_pkg::REL_W-1:0] rel;
    logic [15:0]                prod;
    logic [ttsm_pkg::REL_W-1:0] quot;
    logic [ttsm_pkg::REL_W-1:0] quot3;
    logic [ttsm_pkg::REL_W-1:0] rem;

    ttsm_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;

    // request decode
    always_comb begin
        mode    = ttsm_pkg::t_mode'(i_mode);
        slot_ok = ({3'b000, i_slot} < 7'(SLOTS));
        in_map  = ({1'b0, i_read_index} >= {1'b0, ttsm_pkg::RIX_SLOT_BASE})
                  && ({1'b0, i_read_index} <= MAP_TOP);
        rel     = i_read_index[ttsm_pkg::REL_W-1:0]
                  - ttsm_pkg::RIX_SLOT_BASE[ttsm_pkg::REL_W-1:0];
        prod    = 16'(rel) * ttsm_pkg::RECIP3;
        quot    = ttsm_pkg::REL_W'(prod >> ttsm_pkg::RECIP3_SHIFT);
        quot3   = ttsm_pkg::REL_W'({quot, 1'b0} + {1'b0, quot});
        rem     = rel - quot3;

        dec         = '0;
        dec.time_us = i_time_us;
        dec.slot    = ttsm_pkg::SLOT_CMD_W'(i_slot);
        dec.fsel    = ttsm_pkg::FS_MIN;
        dec.op      = ttsm_pkg::OP_CONST;
        dec.data    = '0;
        unique case (mode)
            ttsm_pkg::MD_TICK: begin
                dec.op = ttsm_pkg::OP_TICK;
            end
            ttsm_pkg::MD_START: begin
                dec.op = slot_ok ? ttsm_pkg::OP_START : ttsm_pkg::OP_CONST;
            end
            ttsm_pkg::MD_STOP: begin
                dec.op = slot_ok ? ttsm_pkg::OP_STOP : ttsm_pkg::OP_CONST;
            end
            ttsm_pkg::MD_READ: begin
                priority if (i_read_index == ttsm_pkg::RIX_ZERO) begin
                    dec.op = ttsm_pkg::OP_CONST;
                end else if (i_read_index == ttsm_pkg::RIX_STACK) begin
                    dec.data = i_stack_peak;
                end else if (i_read_index == ttsm_pkg::RIX_CNT_LO) begin
                    dec.op = ttsm_pkg::OP_CNT_LO;
                end else if (i_read_index == ttsm_pkg::RIX_CNT_HI) begin
                    dec.op = ttsm_pkg::OP_CNT_HI;
                end else if (i_read_index == ttsm_pkg::RIX_TASKS) begin
                    dec.data = 16'(TASKS);
                end else if (in_map) begin
                    dec.op   = ttsm_pkg::OP_SLOT;
                    dec.slot = ttsm_pkg::SLOT_CMD_W'(quot);
                    dec.fsel = ttsm_pkg::t_fsel'(rem[1:0]);
                end else begin
                    dec.op = ttsm_pkg::OP_CONST;
                end
            end
            default: begin
                dec.op = ttsm_pkg::OP_CONST;
            end
        endcase
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({push, i_cmd_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

endmodule

FILE: rtl/ttsm_back.sv
// back end: executes commands against the slot record ram, holds the result
// depends on ttsm_pkg and ttsm_ram
module ttsm_back #(
    parameter int unsigned TASKS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  ttsm_pkg::t_cmd               i_cmd,
    output logic                         o_cmd_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [ttsm_pkg::DATA_W-1:0]  o_read_data,
    output logic [ttsm_pkg::DATA_W-1:0]  o_elapsed_us
);

    localparam int unsigned SLOTS  = TASKS + 1;
    localparam int unsigned SLOT_W = $clog2(SLOTS);
    localparam int unsigned REC_W  = $bits(ttsm_pkg::t_rec);

    ttsm_pkg::t_back_state r_state, n_state;
    ttsm_pkg::t_cmd        r_cmd, n_cmd;
    logic [SLOTS-1:0]      r_vld, n_vld;
    logic [ttsm_pkg::CNT_W-1:0] r_cycle, n_cycle;
    logic                  r_done, n_done;
    logic                  r_out_valid, n_out_valid;
    logic [ttsm_pkg::DATA_W-1:0] r_read_data, n_read_data;
    logic [ttsm_pkg::DATA_W-1:0] r_elapsed, n_elapsed;

    logic [SLOT_W-1:0]     addr;
    logic [REC_W-1:0]      rdata;
    ttsm_pkg::t_rec        entry;
    ttsm_pkg::t_rec        wrec;
    logic                  we;
    logic [ttsm_pkg::DATA_W-1:0] elapsed;

    assign addr = r_cmd.slot[SLOT_W-1:0];

    ttsm_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS),
        .AW    (SLOT_W)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr),
        .i_wdata (wrec),
        .i_raddr (i_cmd.slot[SLOT_W-1:0]),
        .o_rdata (rdata)
    );

    // a record never written reads as its reset value
    assign entry   = r_vld[addr] ? ttsm_pkg::t_rec'(rdata) : ttsm_pkg::REC_RESET;
    assign elapsed = r_cmd.time_us - entry.start_stamp;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_vld       = r_vld;
        n_cycle     = r_cycle;
        n_done      = r_done;
        n_out_valid = r_out_valid && i_stall;
        n_read_data = r_read_data;
        n_elapsed   = r_elapsed;
        o_cmd_pop   = 1'b0;
        we          = 1'b0;
        wrec        = entry;
        unique case (r_state)
            ttsm_pkg::BK_IDLE: begin
                // the ram read is issued here so the record is ready in exec
                if (i_cmd_valid && (!r_out_valid || !i_stall)) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = ttsm_pkg::BK_EXEC;
                end
            end
            ttsm_pkg::BK_EXEC: begin
                n_state     = ttsm_pkg::BK_IDLE;
                n_out_valid = 1'b1;
                n_read_data = '0;
                n_elapsed   = '0;
                unique case (r_cmd.op)
                    ttsm_pkg::OP_TICK: begin
                        n_cycle = r_cycle + 32'd1;
                    end
                    ttsm_pkg::OP_START: begin
                        we               = 1'b1;
                        wrec.start_stamp = r_cmd.time_us;
                        n_vld[addr]      = 1'b1;
                    end
                    ttsm_pkg::OP_STOP: begin
                        we             = 1'b1;
                        n_vld[addr]    = 1'b1;
                        n_elapsed      = elapsed;
                        wrec.last_time = elapsed;
                        if (elapsed < entry.min_time) begin
                            wrec.min_time = elapsed;
                        end
                        if (!r_done) begin
                            // first pass: maxima are not kept yet
                            wrec.max_time = '0;
                            if (r_cmd.slot == ttsm_pkg::SLOT_CMD_W'(TASKS)) begin
                                n_done = 1'b1;
                            end
                        end else if (elapsed > entry.max_time) begin
                            wrec.max_time = elapsed;
                        end
                    end
                    ttsm_pkg::OP_CONST: begin
                        n_read_data = r_cmd.data;
                    end
                    ttsm_pkg::OP_CNT_LO: begin
                        n_read_data = r_cycle[15:0];
                    end
                    ttsm_pkg::OP_CNT_HI: begin
                        n_read_data = r_cycle[31:16];
                    end
                    ttsm_pkg::OP_SLOT: begin
                        unique case (r_cmd.fsel)
                            ttsm_pkg::FS_MIN:  n_read_data = entry.min_time;
                            ttsm_pkg::FS_LAST: n_read_data = entry.last_time;
                            ttsm_pkg::FS_MAX:  n_read_data = entry.max_time;
                            default:           n_read_data = '0;
                        endcase
                    end
                    default: begin
                        n_read_data = '0;
                    end
                endcase
            end
            default: begin
                n_state = ttsm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttsm_pkg::BK_IDLE;
            r_vld       <= '0;
            r_cycle     <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vld       <= n_vld;
            r_cycle     <= n_cycle;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_read_data <= n_read_data;
        r_elapsed   <= n_elapsed;
    end

    assign o_valid      = r_out_valid;
    assign o_read_data  = r_read_data;
    assign o_elapsed_us = r_elapsed;

endmodule

FILE: rtl/task_time_stats_monitor.sv
// a result is registered after its request passes the front queue and the exec state
// the back end takes a new command only in its idle state, after the last one has run
// its exec state, as the registered read and the write-back of a slot record require
// a two-entry queue keeps accepting, until it is full, while a result waits at the output
// reset is synchronous, active low; slot records read their reset values
// through per-slot valid bits, so no clearing pass runs after reset
module task_time_stats_monitor #(
    parameter int unsigned TASKS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_mode,
    input  logic [ttsm_pkg::SLOT_IN_W-1:0]  i_slot,
    input  logic [ttsm_pkg::DATA_W-1:0]     i_time_us,
    input  logic [ttsm_pkg::DATA_W-1:0]     i_read_index,
    input  logic [ttsm_pkg::DATA_W-1:0]     i_stack_peak,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ttsm_pkg::DATA_W-1:0]     o_read_data,
    output logic [ttsm_pkg::DATA_W-1:0]     o_elapsed_us
);

    logic           cmd_valid;
    logic           cmd_pop;
    ttsm_pkg::t_cmd cmd;

    ttsm_front #(
        .TASKS (TASKS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_slot       (i_slot),
        .i_time_us    (i_time_us),
        .i_read_index (i_read_index),
        .i_stack_peak (i_stack_peak),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    ttsm_back #(
        .TASKS (TASKS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_data  (o_read_data),
        .o_elapsed_us (o_elapsed_us)
    );

endmodule

FILE: bench/ttsm_checker.sv
// checker for the task time stats monitor: watches both channels, predicts each
// result word from its own copy of the slot records and counter, and compares
// depends on ttsm_pkg
module ttsm_checker #(
    parameter int unsigned TASKS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    input  logic                         i_req_stall,
    input  logic [1:0]                   i_mode,
    input  logic [ttsm_pkg::SLOT_IN_W-1:0] i_slot,
    input  logic [ttsm_pkg::DATA_W-1:0]  i_time_us,
    input  logic [ttsm_pkg::DATA_W-1:0]  i_read_index,
    input  logic [ttsm_pkg::DATA_W-1:0]  i_stack_peak,
    input  logic                         i_rsp_valid,
    input  logic                         i_rsp_stall,
    input  logic [ttsm_pkg::DATA_W-1:0]  i_read_data,
    input  logic [ttsm_pkg::DATA_W-1:0]  i_elapsed_us,
    output int                           o_mismatches,
    output int                           o_pending
);
    import ttsm_pkg::*;

    localparam int unsigned SLOTS   = TASKS + 1;
    localparam int unsigned MAP_TOP = RIX_SLOT_BASE + 3 * SLOTS - 1;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [DATA_W-1:0] elapsed_us;
    } t_word;

    t_word             expected_words[$];
    logic [DATA_W-1:0] start_stamp[SLOTS];
    logic [DATA_W-1:0] last_elapsed[SLOTS];
    logic [DATA_W-1:0] min_elapsed[SLOTS];
    logic [DATA_W-1:0] max_elapsed[SLOTS];
    logic [CNT_W-1:0]  tick_count;
    logic              warmup_done;
    int                mismatch_count = 0;
    int                result_count   = 0;
    t_word             want;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    task automatic clear_profile();
        for (int s = 0; s < SLOTS; s++) begin
            start_stamp[s]  = '0;
            last_elapsed[s] = '0;
            min_elapsed[s]  = '1;
            max_elapsed[s]  = '0;
        end
        tick_count  = '0;
        warmup_done = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] exp_val);
        if (mismatch_count < 100)
            $display("mismatch at result %0d: %s got %h want %h", result_count, what, got,
                     exp_val);
        mismatch_count++;
    endtask

    function automatic logic [DATA_W-1:0] map_word(logic [DATA_W-1:0] index,
                                                   logic [DATA_W-1:0] peak);
        int rel;
        case (index)
            RIX_ZERO:   return '0;
            RIX_STACK:  return peak;
            RIX_CNT_LO: return tick_count[15:0];
            RIX_CNT_HI: return tick_count[31:16];
            RIX_TASKS:  return DATA_W'(TASKS);
            default: ;
        endcase
        if (index > MAP_TOP)
            return '0;
        rel = int'(index - RIX_SLOT_BASE);
        case (t_fsel'(rel % 3))
            FS_MIN:  return min_elapsed[rel / 3];
            FS_LAST: return last_elapsed[rel / 3];
            default: return max_elapsed[rel / 3];
        endcase
    endfunction

    function automatic t_word apply_request(t_mode mode, logic [SLOT_IN_W-1:0] slot,
                                            logic [DATA_W-1:0] stamp,
                                            logic [DATA_W-1:0] index,
                                            logic [DATA_W-1:0] peak);
        t_word             w;
        logic [DATA_W-1:0] d;
        w = '0;
        case (mode)
            MD_TICK: begin
                tick_count = tick_count + 1'b1;
            end
            MD_START: begin
                if (slot < SLOTS)
                    start_stamp[slot] = stamp;
            end
            MD_STOP: begin
                if (slot < SLOTS) begin
                    d = stamp - start_stamp[slot];
                    last_elapsed[slot] = d;
                    if (d > max_elapsed[slot])
                        max_elapsed[slot] = d;
                    if (d < min_elapsed[slot])
                        min_elapsed[slot] = d;
                    // first pass: max is cleared until the all-tasks slot stops
                    if (!warmup_done) begin
                        max_elapsed[slot] = '0;
                        if (slot == TASKS)
                            warmup_done = 1'b1;
                    end
                    w.elapsed_us = d;
                end
            end
            default: begin
                w.read_data = map_word(index, peak);
            end
        endcase
        return w;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_profile();
            expected_words.delete();
        end else begin
            if (i_req_valid && !i_req_stall)
                expected_words.push_back(apply_request(t_mode'(i_mode), i_slot, i_time_us,
                                                       i_read_index, i_stack_peak));
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("result with no request waiting", i_read_data, '0);
                end else begin
                    want = expected_words.pop_front();
                    if (i_read_data !== want.read_data)
                        report_mismatch("read_data", i_read_data, want.read_data);
                    if (i_elapsed_us !== want.elapsed_us)
                        report_mismatch("elapsed_us", i_elapsed_us, want.elapsed_us);
                end
                result_count++;
            end
        end
        o_pending    <= expected_words.size();
        o_mismatches <= mismatch_count;
    end

endmodule

FILE: bench/tb_top.sv
// top of the task time stats monitor bench: clock, reset, request stimulus,
// random output stalls and the verdict
// depends on ttsm_pkg, task_time_stats_monitor and ttsm_checker
module tb_top;
    import ttsm_pkg::*;

    localparam int unsigned N_TASKS          = 8;
    localparam int unsigned RANDOM_REQUESTS  = 1650;
    localparam int unsigned SETTLE_CYCLES    = 10;
    localparam int unsigned RUN_LIMIT_CYCLES = 2_000_000;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 req_valid      = 1'b0;
    logic                 req_stall;
    logic [1:0]           req_mode       = '0;
    logic [SLOT_IN_W-1:0] req_slot       = '0;
    logic [DATA_W-1:0]    req_time_us    = '0;
    logic [DATA_W-1:0]    req_read_index = '0;
    logic [DATA_W-1:0]    req_stack_peak = '0;
    logic                 rsp_valid;
    logic                 rsp_stall      = 1'b0;
    logic [DATA_W-1:0]    rsp_read_data;
    logic [DATA_W-1:0]    rsp_elapsed_us;

    logic no_idle     = 1'b0;
    int   stall_hold  = 0;
    int   stall_len;
    int   n_sent      = 0;
    int   mismatches;
    int   pending;

    always #10 clk = ~clk;

    task_time_stats_monitor #(
        .TASKS(N_TASKS)
    ) i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (req_valid),
        .o_stall      (req_stall),
        .i_mode       (req_mode),
        .i_slot       (req_slot),
        .i_time_us    (req_time_us),
        .i_read_index (req_read_index),
        .i_stack_peak (req_stack_peak),
        .o_valid      (rsp_valid),
        .i_stall      (rsp_stall),
        .o_read_data  (rsp_read_data),
        .o_elapsed_us (rsp_elapsed_us)
    );

    ttsm_checker #(
        .TASKS(N_TASKS)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_mode       (req_mode),
        .i_slot       (req_slot),
        .i_time_us    (req_time_us),
        .i_read_index (req_read_index),
        .i_stack_peak (req_stack_peak),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_stall  (rsp_stall),
        .i_read_data  (rsp_read_data),
        .i_elapsed_us (rsp_elapsed_us),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_W-1:0] rnd16();
        return DATA_W'($urandom);
    endfunction

    function automatic logic [SLOT_IN_W-1:0] pick_slot();
        if ($urandom_range(0, 99) < 85)
            return SLOT_IN_W'($urandom_range(0, N_TASKS));
        return SLOT_IN_W'($urandom_range(N_TASKS + 1, 15));
    endfunction

    function automatic logic [DATA_W-1:0] pick_read_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return DATA_W'($urandom_range(0, 4 + 3 * (N_TASKS + 1) + 1));
        if (r < 85)
            return DATA_W'($urandom_range(33, 300));
        return rnd16();
    endfunction

    function automatic logic [DATA_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return DATA_W'($urandom_range(0, 200));
        if (r < 75)
            return DATA_W'($urandom_range(0, 5000));
        return rnd16();
    endfunction

    // output stalls, held for a random number of cycles
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_stall  <= 1'b0;
            stall_hold <= 0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (no_idle) begin
            rsp_stall <= 1'b0;
        end else begin
            stall_len = idle_length();
            rsp_stall  <= (stall_len != 0);
            stall_hold <= (stall_len != 0) ? stall_len - 1 : $urandom_range(0, 5);
        end
    end

    task automatic send_request(input t_mode mode, input logic [SLOT_IN_W-1:0] slot,
                                input logic [DATA_W-1:0] stamp,
                                input logic [DATA_W-1:0] index,
                                input logic [DATA_W-1:0] peak);
        int gap;
        req_valid      <= 1'b1;
        req_mode       <= mode;
        req_slot       <= slot;
        req_time_us    <= stamp;
        req_read_index <= index;
        req_stack_peak <= peak;
        do
            @(posedge clk);
        while (req_stall);
        n_sent++;
        gap = no_idle ? 0 : idle_length();
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_read(input logic [DATA_W-1:0] index, input logic [DATA_W-1:0] peak);
        send_request(MD_READ, pick_slot(), rnd16(), index, peak);
    endtask

    task automatic run_directed();
        send_read(RIX_ZERO, rnd16());
        send_read(RIX_STACK, 16'hFFFF);
        send_read(RIX_STACK, 16'h0000);
        send_read(RIX_TASKS, rnd16());
        // untouched slot records: min all ones, max zero
        send_read(RIX_SLOT_BASE, rnd16());
        send_read(DATA_W'(RIX_SLOT_BASE + 3 * N_TASKS + 2), rnd16());
        // past the end of the map and the largest index
        send_read(DATA_W'(RIX_SLOT_BASE + 3 * (N_TASKS + 1)), rnd16());
        send_read(16'hFFFF, rnd16());
        send_request(MD_TICK, pick_slot(), rnd16(), rnd16(), rnd16());
        send_read(RIX_CNT_LO, rnd16());
        send_read(RIX_CNT_HI, rnd16());
        // elapsed time wraps through zero; max stays clear in the first pass
        send_request(MD_START, 4'd0, 16'hFFF0, rnd16(), rnd16());
        send_request(MD_STOP, 4'd0, 16'h0010, rnd16(), rnd16());
        send_read(DATA_W'(RIX_SLOT_BASE + 2), rnd16());
        // slots past the all-tasks slot are ignored
        send_request(MD_START, 4'd15, rnd16(), rnd16(), rnd16());
        send_request(MD_STOP, SLOT_IN_W'(N_TASKS + 1), rnd16(), rnd16(), rnd16());
        // all-tasks stop with the largest elapsed ends the first pass
        send_request(MD_START, SLOT_IN_W'(N_TASKS), 16'h0000, rnd16(), rnd16());
        send_request(MD_STOP, SLOT_IN_W'(N_TASKS), 16'hFFFF, rnd16(), rnd16());
        send_request(MD_START, 4'd0, 16'h1234, rnd16(), rnd16());
        send_request(MD_STOP, 4'd0, 16'h1234, rnd16(), rnd16());
        send_read(RIX_SLOT_BASE, rnd16());
        send_read(DATA_W'(RIX_SLOT_BASE + 2), rnd16());
        send_read(DATA_W'(RIX_SLOT_BASE + 3 * N_TASKS + 2), rnd16());
    endtask

    task automatic run_random();
        int               goal;
        int               s;
        logic [DATA_W-1:0] t0;
        goal = n_sent + RANDOM_REQUESTS;
        while (n_sent < goal) begin
            if ($urandom_range(0, 39) == 0)
                no_idle <= ~no_idle;
            if ($urandom_range(0, 99) < 65) begin
                // timed section: start, a few other requests, stop, read back
                s  = $urandom_range(0, N_TASKS);
                t0 = rnd16();
                send_request(MD_START, SLOT_IN_W'(s), t0, pick_read_index(), rnd16());
                repeat ($urandom_range(0, 3)) begin
                    if ($urandom_range(0, 1) == 0)
                        send_request(MD_TICK, pick_slot(), rnd16(), rnd16(), rnd16());
                    else
                        send_read(pick_read_index(), rnd16());
                end
                // sometimes a stop that does not match the start
                if ($urandom_range(0, 9) == 0)
                    s = $urandom_range(0, 15);
                send_request(MD_STOP, SLOT_IN_W'(s), t0 + pick_duration(), rnd16(), rnd16());
                send_read(DATA_W'(RIX_SLOT_BASE + 3 * s + $urandom_range(0, 2)), rnd16());
            end else begin
                send_request(t_mode'($urandom_range(0, 3)), pick_slot(), rnd16(),
                             pick_read_index(), rnd16());
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_CYCLES * 20);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
